@@ rtl/anxb_pkg.sv @@
// anxb_pkg: shared types, codes and tables for the annex b nal splitter and classifier
`timescale 1ns / 1ps

package anxb_pkg;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_NAL  = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    // exp-golomb decoder stage, one-hot
    typedef enum logic [6:0] {
        GS_IDLE = 7'b0000001,
        GS_Z1   = 7'b0000010,
        GS_V1   = 7'b0000100,
        GS_Z2   = 7'b0001000,
        GS_V2   = 7'b0010000,
        GS_DONE = 7'b0100000,
        GS_LONG = 7'b1000000
    } gstage_t;

    // decoder state; value saturates at VALUE_CAP, enough to saturate the slice kind
    typedef struct packed {
        gstage_t     stage;
        logic [5:0]  zrun;
        logic [5:0]  value;
        logic [3:0]  held;
    } gol_st_t;

    // one finished nal unit
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  prefix;
        logic [23:0] length;
        logic        fzero;
        logic [1:0]  idc;
        logic [4:0]  utype;
        logic [2:0]  fclass;
        logic [3:0]  skind;
    } res_t;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_LEAD     = 2'd1;
    localparam logic [1:0] ST_OVERSIZE    = 2'd2;
    localparam logic [1:0] ST_GOLOMB_LONG = 2'd3;

    // frame classes
    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_I     = 3'd1;
    localparam logic [2:0] CLS_P     = 3'd2;
    localparam logic [2:0] CLS_B     = 3'd3;
    localparam logic [2:0] CLS_SEI   = 3'd4;
    localparam logic [2:0] CLS_SPS   = 3'd5;
    localparam logic [2:0] CLS_PPS   = 3'd6;

    // nal unit types of interest
    localparam logic [4:0] NAL_NON_IDR = 5'd1;
    localparam logic [4:0] NAL_IDR     = 5'd5;
    localparam logic [4:0] NAL_SEI     = 5'd6;
    localparam logic [4:0] NAL_SPS     = 5'd7;
    localparam logic [4:0] NAL_PPS     = 5'd8;

    // start code bytes and prefix lengths
    localparam logic [7:0] SC_ZERO      = 8'h00;
    localparam logic [7:0] SC_ONE       = 8'h01;
    localparam logic [2:0] PREFIX_SHORT = 3'd3;
    localparam logic [2:0] PREFIX_LONG  = 3'd4;

    // decoder limits
    localparam logic [5:0] ZRUN_LIMIT = 6'd32;
    localparam logic [5:0] VALUE_CAP  = 6'd32;
    localparam logic [5:0] VALUE_SAT  = 6'd16;
    localparam logic [3:0] KIND_MAX   = 4'd15;

    // slice_type to frame class
    localparam logic [2:0] CLASS_OF_KIND [0:15] = '{
        CLS_P, CLS_B, CLS_I, CLS_P, CLS_I, CLS_P, CLS_B, CLS_I,
        CLS_P, CLS_I, CLS_OTHER, CLS_OTHER, CLS_OTHER, CLS_OTHER, CLS_OTHER, CLS_OTHER
    };

    // one bit through the ue decoder (two codes back to back)
    function automatic gol_st_t golomb_bit(input gol_st_t s, input logic b);
        gol_st_t r;
        r = s;
        case (s.stage)
            GS_Z1, GS_Z2: begin
                if (!b) begin
                    r.zrun = s.zrun + 6'd1;
                    if (r.zrun >= ZRUN_LIMIT) r.stage = GS_LONG;
                end else if (s.zrun == 6'd0) begin
                    // code "1" means ue value zero
                    if (s.stage == GS_Z1) begin
                        r.stage = GS_Z2;
                    end else begin
                        r.stage = GS_DONE;
                        r.held  = 4'd0;
                    end
                    r.zrun  = 6'd0;
                    r.value = 6'd0;
                end else begin
                    r.stage = (s.stage == GS_Z1) ? GS_V1 : GS_V2;
                    r.value = 6'd1;
                end
            end
            GS_V1, GS_V2: begin
                r.value = (s.value >= VALUE_SAT) ? VALUE_CAP : {s.value[4:0], b};
                r.zrun  = s.zrun - 6'd1;
                if (r.zrun == 6'd0) begin
                    if (s.stage == GS_V1) begin
                        r.stage = GS_Z2;
                    end else begin
                        r.held  = (r.value > 6'd16) ? KIND_MAX : 4'(r.value - 6'd1);
                        r.stage = GS_DONE;
                    end
                    r.zrun  = 6'd0;
                    r.value = 6'd0;
                end
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/anxb_golomb.sv @@
// anxb_golomb: advances the ue decoder over the eight bits of one byte, msb first
`timescale 1ns / 1ps

module anxb_golomb (
    input  anxb_pkg::gol_st_t cur_st,
    input  logic [7:0]        data_byte,
    output anxb_pkg::gol_st_t nxt_st
);
    import anxb_pkg::*;

    // eight chained bit steps on narrow state
    always_comb begin
        gol_st_t st;
        st = cur_st;
        for (int i = 7; i >= 0; i--) begin
            st = golomb_bit(st, data_byte[i]);
        end
        nxt_st = st;
    end

endmodule

@@ rtl/anxb_close.sv @@
// anxb_close: builds the result for a nal unit that is being closed
`timescale 1ns / 1ps

module anxb_close #(
    parameter int LENGTH_BITS = 24
) (
    input  logic [LENGTH_BITS-1:0] byte_count,
    input  logic [1:0]             zero_bytes,
    input  logic [7:0]             header,
    input  anxb_pkg::gol_st_t      gol_st,
    input  logic                   prefix_four,
    input  logic [23:0]            max_bytes,
    output anxb_pkg::res_t         res
);
    import anxb_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_CAP = '1;

    logic                   sat;
    logic [LENGTH_BITS-1:0] len;
    logic [31:0]            len_ext;
    logic [7:0]             hdr;
    logic [10:0]            shifted;
    logic [3:0]             tail_kind;

    // length without the trailing zeros of the next start code
    assign sat     = (byte_count == CNT_CAP);
    assign len     = sat ? CNT_CAP : byte_count - LENGTH_BITS'(zero_bytes);
    assign len_ext = 32'(len);
    assign hdr     = (len != '0) ? header : 8'd0;

    // slice_type still open at the end: missing bits read as zero
    assign shifted   = 11'(gol_st.value) << gol_st.zrun[2:0];
    assign tail_kind = (gol_st.zrun >= 6'd5 || shifted > 11'd16) ? KIND_MAX
                                                                 : 4'(shifted - 11'd1);

    // classify and set status
    always_comb begin
        res        = '0;
        res.prefix = prefix_four ? PREFIX_LONG : PREFIX_SHORT;
        res.length = (len_ext > 32'h00FF_FFFF) ? 24'hFF_FFFF : len_ext[23:0];
        res.fzero  = hdr[7];
        res.idc    = hdr[6:5];
        res.utype  = hdr[4:0];
        res.status = ST_OK;
        if (hdr[4:0] inside {NAL_NON_IDR, NAL_IDR}) begin
            if (gol_st.stage == GS_V2) begin
                res.skind  = tail_kind;
                res.fclass = CLASS_OF_KIND[tail_kind];
            end else if (gol_st.stage == GS_DONE) begin
                res.skind  = gol_st.held;
                res.fclass = CLASS_OF_KIND[gol_st.held];
            end else begin
                res.status = ST_GOLOMB_LONG;
            end
        end else if (hdr[4:0] == NAL_SEI) begin
            res.fclass = CLS_SEI;
        end else if (hdr[4:0] == NAL_SPS) begin
            res.fclass = CLS_SPS;
        end else if (hdr[4:0] == NAL_PPS) begin
            res.fclass = CLS_PPS;
        end
        if (sat || len_ext > {8'd0, max_bytes}) begin
            res.status = ST_OVERSIZE;
        end
    end

endmodule

@@ rtl/annexb_nal_splitter_classifier_core.sv @@
// annexb_nal_splitter_classifier_core: annex b start code scan, nal split and header classify
//
//  port group | dir | handshake          | content
//  s_*        | in  | s_tvalid/s_tready  | stream byte, s_tlast on the buffer's last byte
//  m_*        | out | m_tvalid/m_tready  | one result per finished nal unit
//  cfg_*      | in  | cfg_valid/cfg_ready| max_nal_bytes
//
// one byte per cycle while no result is held waiting on m_tready; a byte passes the input
// register and then the result register before its result is shown.
// the ue decode walks all eight bits of a byte combinationally, which sets the path.
// aresetn is synchronous, active low; max_nal_bytes returns to 1048576.
// with m_tready low the result holds and one more byte waits in the input register.
`timescale 1ns / 1ps

module annexb_nal_splitter_classifier_core #(
    parameter int LENGTH_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  logic        s_tlast,   // end_of_buffer
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] nal_status, [4:2] prefix_length, [28:5] payload_length, [29] forbidden_zero,
    // [31:30] reference_idc, [36:32] unit_type, [39:37] frame_class, [43:40] slice_kind,
    // [47:44] zero
    output logic [47:0] m_tdata,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    import anxb_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_CAP = '1;

    // input register
    logic                   in_vld_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    // result register
    logic                   out_vld_reg;
    res_t                   out_res_reg;
    // configuration
    logic [23:0]            max_reg;
    // parser state
    phase_t                 phase_reg, phase_next;
    logic [23:0]            recent_reg, recent_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   four_reg, four_next;
    logic [7:0]             header_reg, header_next;
    gol_st_t                gol_reg, gol_next;

    logic                   proc_go;
    logic                   res_vld;
    res_t                   res;
    logic [7:0]             b;
    logic                   eob;

    // lead and body helpers
    logic                   lead_ok, lead_done, lead_four;
    logic                   start_hit, start_four;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [7:0]             header_body;
    gol_st_t                gol_fed, gol_body;
    logic                   go_open, go_clear, open_four;

    // close inputs
    logic [LENGTH_BITS-1:0] cl_count;
    logic [1:0]             cl_zeros;
    logic [7:0]             cl_header;
    gol_st_t                cl_gol;
    res_t                   cl_res;

    // handshakes
    assign proc_go   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || proc_go;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {4'd0, out_res_reg.skind, out_res_reg.fclass, out_res_reg.utype,
                        out_res_reg.idc, out_res_reg.fzero, out_res_reg.length,
                        out_res_reg.prefix, out_res_reg.status};

    assign b   = in_byte_reg;
    assign eob = in_last_reg;

    // leading start code check
    always_comb begin
        lead_ok   = 1'b0;
        lead_done = 1'b0;
        lead_four = 1'b0;
        if (count_reg < LENGTH_BITS'(2)) begin
            lead_ok = (b == SC_ZERO);
        end else if (count_reg == LENGTH_BITS'(2)) begin
            if (b == SC_ONE) lead_done = 1'b1;
            else             lead_ok   = (b == SC_ZERO);
        end else if (b == SC_ONE) begin
            lead_done = 1'b1;
            lead_four = 1'b1;
        end
    end

    // start code inside a nal unit
    assign start_hit  = (b == SC_ONE) && (recent_reg[15:0] == 16'd0);
    assign start_four = (recent_reg[23:16] == 8'd0);
    assign count_inc  = (count_reg == CNT_CAP) ? count_reg : count_reg + 1'b1;

    anxb_golomb u_golomb (
        .cur_st    (gol_reg),
        .data_byte (b),
        .nxt_st    (gol_fed)
    );

    // header byte arms the decoder for slices, later bytes feed it
    always_comb begin
        header_body = header_reg;
        gol_body    = gol_fed;
        if (count_reg == '0) begin
            header_body = b;
            gol_body    = gol_reg;
            if (b[4:0] inside {NAL_NON_IDR, NAL_IDR}) begin
                gol_body.stage = GS_Z1;
                gol_body.zrun  = 6'd0;
                gol_body.value = 6'd0;
            end
        end
    end

    // close on the old state at a start code, on the updated state at end of buffer
    assign cl_count  = start_hit ? count_reg : count_inc;
    assign cl_zeros  = start_hit ? (start_four ? 2'd3 : 2'd2) : 2'd0;
    assign cl_header = start_hit ? header_reg : header_body;
    assign cl_gol    = start_hit ? gol_reg : gol_body;

    anxb_close #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_close (
        .byte_count  (cl_count),
        .zero_bytes  (cl_zeros),
        .header      (cl_header),
        .gol_st      (cl_gol),
        .prefix_four (four_reg),
        .max_bytes   (max_reg),
        .res         (cl_res)
    );

    // parser next state and result
    always_comb begin
        phase_next  = phase_reg;
        recent_next = recent_reg;
        count_next  = count_reg;
        four_next   = four_reg;
        header_next = header_reg;
        gol_next    = gol_reg;
        res_vld     = 1'b0;
        res         = '0;
        go_open     = 1'b0;
        go_clear    = 1'b0;
        open_four   = 1'b0;
        case (phase_reg)
            PH_LEAD: begin
                if (lead_done) begin
                    go_open   = 1'b1;
                    open_four = lead_four;
                    go_clear  = eob;
                end else if (lead_ok && !eob) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    res_vld    = 1'b1;
                    res.status = ST_NO_LEAD;
                    if (eob || lead_ok) go_clear   = 1'b1;
                    else                phase_next = PH_SKIP;
                end
            end
            PH_NAL: begin
                if (start_hit) begin
                    res_vld   = 1'b1;
                    res       = cl_res;
                    go_open   = 1'b1;
                    open_four = start_four;
                    go_clear  = eob;
                end else begin
                    header_next = header_body;
                    gol_next    = gol_body;
                    count_next  = count_inc;
                    recent_next = {recent_reg[15:0], b};
                    if (eob) begin
                        res_vld  = 1'b1;
                        res      = cl_res;
                        go_clear = 1'b1;
                    end
                end
            end
            PH_SKIP: begin
                go_clear = eob;
            end
            default: begin
                go_clear = 1'b1;
            end
        endcase
        // open a new unit from clean state
        if (go_open) begin
            phase_next  = PH_NAL;
            recent_next = 24'hFF_FFFF;
            count_next  = '0;
            four_next   = open_four;
            header_next = 8'd0;
            gol_next    = '{stage: GS_IDLE, zrun: 6'd0, value: 6'd0, held: 4'd0};
        end
        // end of buffer (or an illegal phase) returns the parser state to reset
        if (go_clear) begin
            phase_next  = PH_LEAD;
            recent_next = 24'hFF_FFFF;
            count_next  = '0;
            four_next   = 1'b0;
            header_next = 8'd0;
            gol_next    = '{stage: GS_IDLE, zrun: 6'd0, value: 6'd0, held: 4'd0};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            max_reg     <= 24'd1048576;
            phase_reg   <= PH_LEAD;
            recent_reg  <= 24'hFF_FFFF;
            count_reg   <= '0;
            four_reg    <= 1'b0;
            header_reg  <= 8'd0;
            gol_reg     <= '{stage: GS_IDLE, zrun: 6'd0, value: 6'd0, held: 4'd0};
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (proc_go) begin
                in_vld_reg <= 1'b0;
            end
            if (proc_go) begin
                out_vld_reg <= res_vld;
                phase_reg   <= phase_next;
                recent_reg  <= recent_next;
                count_reg   <= count_next;
                four_reg    <= four_next;
                header_reg  <= header_next;
                gol_reg     <= gol_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                max_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_go && res_vld) begin
            out_res_reg <= res;
        end
    end

`ifndef SYNTHESIS
    // a no-lead result carries nothing else
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_res_reg.status == ST_NO_LEAD) |->
            (out_res_reg.prefix == 3'd0 && out_res_reg.length == 24'd0))
        else $error("no-lead result with nonzero fields");

    // a real unit was opened by a three or four byte prefix
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_res_reg.status != ST_NO_LEAD) |->
            (out_res_reg.prefix == PREFIX_SHORT || out_res_reg.prefix == PREFIX_LONG))
        else $error("bad prefix length on result");

    // an empty unit has no header
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_res_reg.length == 24'd0) |->
            (out_res_reg.utype == 5'd0 && out_res_reg.fclass == CLS_OTHER))
        else $error("empty unit with header fields");

    // the decoder runs only behind a slice header
    assert property (@(posedge aclk) disable iff (!aresetn)
        (gol_reg.stage != GS_IDLE) |->
            (header_reg[4:0] == NAL_NON_IDR || header_reg[4:0] == NAL_IDR))
        else $error("ue decoder active outside a slice");

    // skipping bytes never gives a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> !res_vld)
        else $error("result while skipping");
`endif

endmodule
